### sv/rgbansi_pkg.sv
// Shared types, constants and helpers for the RGB to truecolor terminal encoder.
// Used by the front, queue, back and top modules; depends on nothing else.
package rgbansi_pkg;

   localparam int MAX_DIM  = 1024;
   localparam int CNT_W    = $clog2(MAX_DIM);
   localparam int CFG_W    = 11;
   localparam int CSR_IDX_W = 8;
   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 8'd1;
   localparam logic [CFG_W-1:0] COLUMNS_RESET = 11'd80;
   localparam logic [CFG_W-1:0] ROWS_RESET    = 11'd24;

   localparam logic [7:0] CHAR_ESC   = 8'h1b;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_M     = 8'h6d;

   localparam logic [7:0] SEQ_HOME [0:2] = '{8'h1b, 8'h5b, 8'h48};
   localparam logic [7:0] SEQ_COLOR [0:6] =
      '{8'h1b, 8'h5b, 8'h33, 8'h38, 8'h3b, 8'h32, 8'h3b};
   localparam logic [7:0] SEQ_GLYPHS [0:5] =
      '{8'he2, 8'h96, 8'h88, 8'he2, 8'h96, 8'h88};
   localparam logic [7:0] SEQ_ROW_END [0:5] =
      '{8'h1b, 8'h5b, 8'h30, 8'h6d, 8'h0a, 8'h0d};
   localparam logic [7:0] SEQ_RESET [0:3] = '{8'h1b, 8'h5b, 8'h30, 8'h6d};

   typedef logic [2:0][3:0] digits_type;

   typedef struct packed {
      logic       home;
      logic       color;
      logic       row_end;
      logic       frame_end;
      digits_type red_dig;
      digits_type green_dig;
      digits_type blue_dig;
   } entry_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_HOME,
      PH_COLOR,
      PH_RED,
      PH_SEMI1,
      PH_GREEN,
      PH_SEMI2,
      PH_BLUE,
      PH_M,
      PH_GLYPH,
      PH_ROW_END,
      PH_RESET
   } phase_type;

   // Decimal digits of an 8-bit value, hundreds in element 2 and units in element 0.
   function automatic digits_type to_digits(input logic [7:0] v);
      logic [1:0]  h;
      logic [7:0]  rem;
      logic [15:0] prod;
      logic [3:0]  t;
      logic [7:0]  u;
      digits_type  d;
      if (v >= 8'd200) begin
         h = 2'd2;
      end else if (v >= 8'd100) begin
         h = 2'd1;
      end else begin
         h = 2'd0;
      end
      rem  = v - 8'(h * 8'd100);
      prod = 16'(rem) * 16'd205;
      t    = prod[14:11];
      u    = rem - 8'(t * 8'd10);
      d[2] = {2'b00, h};
      d[1] = t;
      d[0] = u[3:0];
      return d;
   endfunction

endpackage

### sv/rgbansi_front.sv
// Front end: accepts pixels, tracks position and last colour, and builds queue entries.
// Depends on rgbansi_pkg.
module rgbansi_front import rgbansi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 q_full,
   output logic                 push,
   output entry_type            push_entry
);

   localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

   logic [CFG_W-1:0] columns_ff, columns_in;
   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [7:0]       prev_red_ff, prev_red_in;
   logic [7:0]       prev_green_ff, prev_green_in;
   logic [7:0]       prev_blue_ff, prev_blue_in;
   logic             prev_valid_ff, prev_valid_in;
   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;

   logic [CMP_W-1:0] ncol, nrow, col_next, row_next;
   logic             row_end, frame_end, home, color;

   function automatic logic [CMP_W-1:0] effective(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (v == '0) begin
         return CMP_W'(1);
      end else if (ext > CMP_W'(MAX_DIM)) begin
         return CMP_W'(MAX_DIM);
      end
      return ext;
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      ncol      = effective(columns_ff);
      nrow      = effective(rows_ff);
      col_next  = CMP_W'(column_count_ff) + CMP_W'(1);
      row_next  = CMP_W'(row_count_ff) + CMP_W'(1);
      row_end   = col_next >= ncol;
      frame_end = row_end && (row_next >= nrow);
      home      = (column_count_ff == '0) && (row_count_ff == '0);
      color     = !prev_valid_ff || (req_red != prev_red_ff) ||
                  (req_green != prev_green_ff) || (req_blue != prev_blue_ff);

      push_entry.home      = home;
      push_entry.color     = color;
      push_entry.row_end   = row_end;
      push_entry.frame_end = frame_end;
      push_entry.red_dig   = to_digits(req_red);
      push_entry.green_dig = to_digits(req_green);
      push_entry.blue_dig  = to_digits(req_blue);
   end

   always_comb begin
      columns_in      = columns_ff;
      rows_in         = rows_ff;
      prev_red_in     = prev_red_ff;
      prev_green_in   = prev_green_ff;
      prev_blue_in    = prev_blue_ff;
      prev_valid_in   = prev_valid_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_COLUMNS) begin
            columns_in = csr_data;
         end else if (csr_index == CSR_ROWS) begin
            rows_in = csr_data;
         end
      end
      if (push) begin
         if (color) begin
            prev_red_in   = req_red;
            prev_green_in = req_green;
            prev_blue_in  = req_blue;
         end
         prev_valid_in = !row_end;
         if (row_end) begin
            column_count_in = '0;
            row_count_in    = frame_end ? '0 : row_count_ff + 1'b1;
         end else begin
            column_count_in = column_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff      <= COLUMNS_RESET;
         rows_ff         <= ROWS_RESET;
         prev_red_ff     <= '0;
         prev_green_ff   <= '0;
         prev_blue_ff    <= '0;
         prev_valid_ff   <= 1'b0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         columns_ff      <= columns_in;
         rows_ff         <= rows_in;
         prev_red_ff     <= prev_red_in;
         prev_green_ff   <= prev_green_in;
         prev_blue_ff    <= prev_blue_in;
         prev_valid_ff   <= prev_valid_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule

### sv/rgbansi_queue.sv
// Short FIFO of classified pixels between the front end and the byte sequencer.
// Depends on rgbansi_pkg.
module rgbansi_queue import rgbansi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      q_full,
   output logic      q_valid,
   input  logic      pop,
   output entry_type head
);

   entry_type          mem [0:Q_DEPTH-1];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   function automatic logic [Q_PTR_W-1:0] bump(input logic [Q_PTR_W-1:0] p);
      if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign q_full  = count_ff == Q_CNT_W'(Q_DEPTH);
   assign q_valid = count_ff != '0;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("Queue written while full.");
   assert property (@(posedge clock) disable iff (reset) pop |-> q_valid)
      else $error("Queue read while empty.");

endmodule

### sv/rgbansi_back.sv
// Byte sequencer: walks the escape, digit and glyph phases of the head entry.
// Depends on rgbansi_pkg; fed by rgbansi_queue.
module rgbansi_back import rgbansi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_pixel,
   output logic       rsp_last_of_frame
);

   phase_type  state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       last_pixel_ff, last_pixel_in;
   logic       last_frame_ff, last_frame_in;

   phase_type  cur_phase, nxt_phase;
   logic [2:0] cur_idx, last_idx;
   logic       adv, fire, phase_end, done;
   digits_type cur_dig;
   logic [1:0] skip, pos;

   function automatic phase_type next_phase(input phase_type p, input entry_type e);
      phase_type n;
      unique case (p)
         PH_START:   n = e.home ? PH_HOME : (e.color ? PH_COLOR : PH_GLYPH);
         PH_HOME:    n = e.color ? PH_COLOR : PH_GLYPH;
         PH_COLOR:   n = PH_RED;
         PH_RED:     n = PH_SEMI1;
         PH_SEMI1:   n = PH_GREEN;
         PH_GREEN:   n = PH_SEMI2;
         PH_SEMI2:   n = PH_BLUE;
         PH_BLUE:    n = PH_M;
         PH_M:       n = PH_GLYPH;
         PH_GLYPH:   n = e.row_end ? PH_ROW_END : PH_START;
         PH_ROW_END: n = e.frame_end ? PH_RESET : PH_START;
         PH_RESET:   n = PH_START;
         default:    n = PH_START;
      endcase
      return n;
   endfunction

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign fire      = adv && q_valid;
   assign cur_phase = (state_ff == PH_START) ? next_phase(PH_START, head) : state_ff;
   assign cur_idx   = (state_ff == PH_START) ? 3'd0 : idx_ff;
   assign nxt_phase = next_phase(cur_phase, head);
   assign phase_end = cur_idx == last_idx;
   assign done      = phase_end && (nxt_phase == PH_START);
   assign pop       = fire && done;

   always_comb begin
      unique case (cur_phase)
         PH_RED:   cur_dig = head.red_dig;
         PH_GREEN: cur_dig = head.green_dig;
         default:  cur_dig = head.blue_dig;
      endcase
      priority if (cur_dig[2] != 4'd0) begin
         skip = 2'd0;
      end else if (cur_dig[1] != 4'd0) begin
         skip = 2'd1;
      end else begin
         skip = 2'd2;
      end
      pos = 2'd2 - (cur_idx[1:0] + skip);
      unique case (cur_phase)
         PH_HOME:    last_idx = 3'd2;
         PH_COLOR:   last_idx = 3'd6;
         PH_RED, PH_GREEN, PH_BLUE: last_idx = 3'(2'd2 - skip);
         PH_GLYPH:   last_idx = 3'd5;
         PH_ROW_END: last_idx = 3'd5;
         PH_RESET:   last_idx = 3'd3;
         default:    last_idx = 3'd0;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      if (fire) begin
         if (phase_end) begin
            state_in = nxt_phase;
            idx_in   = 3'd0;
         end else begin
            state_in = cur_phase;
            idx_in   = cur_idx + 3'd1;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      last_pixel_in = last_pixel_ff;
      last_frame_in = last_frame_ff;
      if (adv) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         unique case (cur_phase)
            PH_HOME:    out_byte_in = SEQ_HOME[cur_idx[1:0]];
            PH_COLOR:   out_byte_in = SEQ_COLOR[cur_idx];
            PH_RED, PH_GREEN, PH_BLUE: out_byte_in = CHAR_ZERO + 8'(cur_dig[pos]);
            PH_SEMI1, PH_SEMI2: out_byte_in = CHAR_SEMI;
            PH_M:       out_byte_in = CHAR_M;
            PH_GLYPH:   out_byte_in = SEQ_GLYPHS[cur_idx];
            PH_ROW_END: out_byte_in = SEQ_ROW_END[cur_idx];
            PH_RESET:   out_byte_in = SEQ_RESET[cur_idx[1:0]];
            default:    out_byte_in = CHAR_ESC;
         endcase
         last_pixel_in = done;
         last_frame_in = done && head.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_START;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      last_pixel_ff <= last_pixel_in;
      last_frame_ff <= last_frame_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_last_of_pixel = last_pixel_ff;
   assign rsp_last_of_frame = last_frame_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != PH_START) |-> q_valid)
      else $error("Sequencer is inside a pixel with an empty queue.");
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && last_pixel_ff)
      else $error("Entry retired without a final byte.");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_frame_ff) |-> last_pixel_ff)
      else $error("Frame end flagged on a byte that does not close a pixel.");

endmodule

### sv/rgb_pixels_to_ansi_truecolor_stream_top.sv
// Top level of the RGB to truecolor terminal encoder.
// Depends on rgbansi_pkg, rgbansi_front, rgbansi_queue and rgbansi_back.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_red, req_green, req_blue
//   rsp      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_last_of_pixel,
//                                            rsp_last_of_frame
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One byte leaves per cycle unless the output stalls; a pixel has 6 to 38 bytes, set by
// the byte sequencer in the back end. Pixels are accepted into a two-entry queue while
// earlier pixels are still being sent. A result passes through the queue and then the
// back end's output register. Reset is synchronous and restores columns 80 and rows 24.
// An output stall holds the sequencer; the input stalls only when the queue is full.
module rgb_pixels_to_ansi_truecolor_stream_top import rgbansi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_pixel,
   output logic                 rsp_last_of_frame,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   logic      push, q_full, q_valid, pop;
   entry_type push_entry, head;

   rgbansi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rgbansi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .pop        (pop),
      .head       (head)
   );

   rgbansi_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_pixel (rsp_last_of_pixel),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
